// File: rtl/pst_pkg.sv
// Shared types and constants for the priority sorted table.
package pst_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PRIO_W = 16;
   localparam int HDL_W = 16;
   localparam int WORD_W = PRIO_W + HDL_W;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_REMOVED  = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Table port control from the sequencer.
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } tbl_ctl_type;

   // Outcome of the shared key compare.
   typedef struct packed {
      logic gt;  // key above entry priority
      logic eq;  // key equals entry priority
   } cmp_res_type;

endpackage

// File: rtl/pst_table.sv
// Entry storage: one write port, one registered read port.
module pst_table (
   input  logic                       clock,
   input  pst_pkg::tbl_ctl_type       ctl,
   output logic [pst_pkg::WORD_W-1:0] rd_data
);

   logic [pst_pkg::WORD_W-1:0] mem [pst_pkg::DEPTH];
   logic [pst_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pst_cmp.sv
// Shared signed priority comparator.
module pst_cmp (
   input  logic [pst_pkg::PRIO_W-1:0] key,
   input  logic [pst_pkg::PRIO_W-1:0] prio,
   output pst_pkg::cmp_res_type       res
);

   always_comb begin
      res.gt = $signed(key) > $signed(prio);
      res.eq = key == prio;
   end

endmodule

// File: rtl/priority_sorted_table_core.sv
// Top level: sequencer for the priority sorted table around one comparator.
// Insert: each stored entry that the key does not beat is read and moved up one slot, then
//   the new entry is written and the result issued; a rejected insert into a full table only answers.
// Remove: scans the entries for the run of matching priorities, emits one result per run entry,
//   then compacts the entries behind the run; a miss gives a single no-match result.
// One request at a time; req_tready is high only while the sequencer idles. Reset (sync,
//   active high) empties the table.
module priority_sorted_table_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] priority_req, [31:16] guest_handle
   input  logic [0:0]  req_tuser,   // [0] operation
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] out_priority, [31:16] out_handle
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   localparam int CW = pst_pkg::CNT_W;
   localparam int IW = pst_pkg::IDX_W;
   localparam int PW = pst_pkg::PRIO_W;
   localparam int HW = pst_pkg::HDL_W;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_INS_RD   = 11'b00000000010,
      S_INS_CHK  = 11'b00000000100,
      S_INS_PUT  = 11'b00000001000,
      S_RESP     = 11'b00000010000,
      S_REM_RD   = 11'b00000100000,
      S_REM_CHK  = 11'b00001000000,
      S_EMIT_RD  = 11'b00010000000,
      S_EMIT_OUT = 11'b00100000000,
      S_CMP_RD   = 11'b01000000000,
      S_CMP_WR   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // Entry count and scan pointers
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] first_ff, first_in;
   logic [CW-1:0] end_ff, end_in;
   logic [CW-1:0] run_ff, run_in;
   logic          found_ff, found_in;

   // Latched request
   logic [PW-1:0] key_ff, key_in;
   logic [HW-1:0] hdl_ff, hdl_in;
   pst_pkg::status_type code_ff, code_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [PW-1:0] rsp_prio_ff, rsp_prio_in;
   logic [HW-1:0] rsp_hdl_ff, rsp_hdl_in;
   logic          rsp_last_ff, rsp_last_in;

   pst_pkg::tbl_ctl_type        tbl_ctl;
   logic [pst_pkg::WORD_W-1:0]  rd_data;
   pst_pkg::cmp_res_type        cmp_res;

   logic          req_fire;
   logic          out_free;
   logic [CW-1:0] idx_m1;
   logic [CW-1:0] idx_p1;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] dst_idx;

   pst_table u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .rd_data (rd_data)
   );

   pst_cmp u_cmp (
      .key  (key_ff),
      .prio (rd_data[pst_pkg::WORD_W-1:HW]),
      .res  (cmp_res)
   );

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign idx_m1     = idx_ff - CW'(1);
   assign idx_p1     = idx_ff + CW'(1);
   assign cnt_m1     = cnt_ff - CW'(1);
   assign dst_idx    = idx_ff - run_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_hdl_ff, rsp_prio_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      first_in      = first_ff;
      end_in        = end_ff;
      run_in        = run_ff;
      found_in      = found_ff;
      key_in        = key_ff;
      hdl_in        = hdl_ff;
      code_in       = code_ff;
      rsp_status_in = rsp_status_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_hdl_in    = rsp_hdl_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      tbl_ctl.wr_en   = 1'b0;
      tbl_ctl.wr_addr = idx_ff[IW-1:0];
      tbl_ctl.wr_data = rd_data;
      tbl_ctl.rd_en   = 1'b0;
      tbl_ctl.rd_addr = idx_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in   = req_tdata[PW-1:0];
               hdl_in   = req_tdata[PW+HW-1:PW];
               found_in = 1'b0;
               if (req_tuser[0] == pst_pkg::OP_INSERT) begin
                  idx_in = cnt_ff;
                  if (cnt_ff == CW'(pst_pkg::DEPTH)) begin
                     code_in  = pst_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else if (cnt_ff == '0) begin
                     state_in = S_INS_PUT;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end else begin
                  idx_in = '0;
                  if (cnt_ff == '0) begin
                     code_in  = pst_pkg::ST_NONE;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_REM_RD;
                  end
               end
            end
         end

         // Walk down from the tail, moving every entry the key does not beat.
         S_INS_RD: begin
            tbl_ctl.rd_en   = 1'b1;
            tbl_ctl.rd_addr = idx_m1[IW-1:0];
            state_in        = S_INS_CHK;
         end

         S_INS_CHK: begin
            if (cmp_res.gt) begin
               state_in = S_INS_PUT;
            end else begin
               tbl_ctl.wr_en = 1'b1;
               idx_in        = idx_m1;
               state_in      = (idx_ff == CW'(1)) ? S_INS_PUT : S_INS_RD;
            end
         end

         S_INS_PUT: begin
            tbl_ctl.wr_en   = 1'b1;
            tbl_ctl.wr_data = {key_ff, hdl_ff};
            cnt_in          = cnt_ff + CW'(1);
            code_in         = pst_pkg::ST_INSERTED;
            state_in        = S_RESP;
         end

         // Single result: inserted, full or no match
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = code_ff;
               rsp_prio_in   = key_ff;
               rsp_hdl_in    = (code_ff == pst_pkg::ST_NONE) ? '0 : hdl_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // Forward scan for the run of matching priorities
         S_REM_RD: begin
            tbl_ctl.rd_en = 1'b1;
            state_in      = S_REM_CHK;
         end

         S_REM_CHK: begin
            if (cmp_res.eq) begin
               if (!found_ff) begin
                  first_in = idx_ff;
                  found_in = 1'b1;
               end
               idx_in = idx_p1;
               if (idx_ff == cnt_m1) begin
                  end_in   = cnt_ff;
                  run_in   = cnt_ff - (found_ff ? first_ff : idx_ff);
                  idx_in   = idx_ff;
                  state_in = S_EMIT_RD;
               end else begin
                  state_in = S_REM_RD;
               end
            end else if (found_ff) begin
               end_in   = idx_ff;
               run_in   = idx_ff - first_ff;
               idx_in   = idx_m1;
               state_in = S_EMIT_RD;
            end else if (!cmp_res.gt || idx_ff == cnt_m1) begin
               // passed the key in sorted order, or hit the tail
               code_in  = pst_pkg::ST_NONE;
               state_in = S_RESP;
            end else begin
               idx_in   = idx_p1;
               state_in = S_REM_RD;
            end
         end

         // Emit the run tail first, which is oldest first
         S_EMIT_RD: begin
            tbl_ctl.rd_en = 1'b1;
            state_in      = S_EMIT_OUT;
         end

         S_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pst_pkg::ST_REMOVED;
               rsp_prio_in   = rd_data[pst_pkg::WORD_W-1:HW];
               rsp_hdl_in    = rd_data[HW-1:0];
               rsp_last_in   = idx_ff == first_ff;
               if (idx_ff == first_ff) begin
                  idx_in = end_ff;
                  if (end_ff == cnt_ff) begin
                     cnt_in   = cnt_ff - run_ff;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_CMP_RD;
                  end
               end else begin
                  idx_in   = idx_m1;
                  state_in = S_EMIT_RD;
               end
            end
         end

         // Close the gap left by the run
         S_CMP_RD: begin
            tbl_ctl.rd_en = 1'b1;
            state_in      = S_CMP_WR;
         end

         S_CMP_WR: begin
            tbl_ctl.wr_en   = 1'b1;
            tbl_ctl.wr_addr = dst_idx[IW-1:0];
            idx_in          = idx_p1;
            if (idx_ff == cnt_m1) begin
               cnt_in   = cnt_ff - run_ff;
               state_in = S_IDLE;
            end else begin
               state_in = S_CMP_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      first_ff      <= first_in;
      end_ff        <= end_in;
      run_ff        <= run_in;
      key_ff        <= key_in;
      hdl_ff        <= hdl_in;
      code_ff       <= code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_hdl_ff    <= rsp_hdl_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// File: test/priority_sorted_table_core_test.sv
// Self-checking testbench for the priority sorted table core.
`timescale 1ns / 1ps

module priority_sorted_table_core_test;

   localparam int CLK_HALF    = 4;
   localparam int RESET_LEN   = 10;
   localparam int CYCLE_LIMIT = 600000;  // far above a slow run with all stalls
   localparam int DRAIN_WAIT  = 200;
   localparam int POOL_SIZE   = 8;
   localparam int DEPTH       = pst_pkg::DEPTH;

   // One result as the table should report it.
   typedef struct {
      pst_pkg::status_type status;
      logic signed [15:0]  prio;
      logic [15:0]         handle;
      logic                last;
   } table_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] priority_req, [31:16] guest_handle
   logic [0:0]  req_tuser = '0;   // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [15:0] out_priority, [31:16] out_handle
   logic [1:0]  rsp_tuser;        // [1:0] status
   logic        rsp_tlast;

   // Shadow copy of the table, kept sorted the same way as the block.
   logic signed [15:0] shadow_prio [DEPTH];
   logic [15:0]        shadow_handle [DEPTH];
   int                 shadow_count = 0;

   table_outcome_type pending_outcomes [$];

   // Idle rates in percent, changed per phase.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int cycle_count    = 0;
   int error_count    = 0;
   int requests_sent  = 0;
   int results_seen   = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int longest_run    = 0;
   int run_length     = 0;

   logic signed [15:0] key_pool [POOL_SIZE];

   priority_sorted_table_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #CLK_HALF clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_outcomes.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic table_outcome_type make_outcome(pst_pkg::status_type st,
                                                      logic signed [15:0] p,
                                                      logic [15:0] h, logic l);
      table_outcome_type o;
      o.status = st;
      o.prio   = p;
      o.handle = h;
      o.last   = l;
      return o;
   endfunction

   // Apply one accepted request to the shadow table and queue what the block
   // must answer. Insert goes ahead of the first entry with priority >= key,
   // so equal keys sit newest first; a remove emits that run back to front.
   task automatic predict_table_request(input logic op, input logic signed [15:0] key,
                                        input logic [15:0] hdl);
      int slot;
      int stop;
      int run;
      slot = 0;
      if (op == pst_pkg::OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            pending_outcomes.push_back(make_outcome(pst_pkg::ST_FULL, key, hdl, 1'b1));
         end else begin
            while (slot < shadow_count && key > shadow_prio[slot]) slot++;
            for (int i = shadow_count; i > slot; i--) begin
               shadow_prio[i]   = shadow_prio[i-1];
               shadow_handle[i] = shadow_handle[i-1];
            end
            shadow_prio[slot]   = key;
            shadow_handle[slot] = hdl;
            shadow_count++;
            pending_outcomes.push_back(make_outcome(pst_pkg::ST_INSERTED, key, hdl, 1'b1));
         end
      end else begin
         while (slot < shadow_count && shadow_prio[slot] != key) slot++;
         if (slot >= shadow_count) begin
            pending_outcomes.push_back(make_outcome(pst_pkg::ST_NONE, key, 16'h0000, 1'b1));
         end else begin
            stop = slot;
            while (stop < shadow_count && shadow_prio[stop] == key) stop++;
            // oldest of the run sits at the high end
            for (int i = stop - 1; i >= slot; i--)
               pending_outcomes.push_back(make_outcome(pst_pkg::ST_REMOVED, shadow_prio[i],
                                                       shadow_handle[i], i == slot));
            run = stop - slot;
            for (int i = stop; i < shadow_count; i++) begin
               shadow_prio[i-run]   = shadow_prio[i];
               shadow_handle[i-run] = shadow_handle[i];
            end
            shadow_count -= run;
         end
      end
   endtask

   // Send one request. Valid stays high across back-to-back requests and is
   // only dropped while the sender takes a random gap or after the last request.
   task automatic send_request(input logic op, input logic signed [15:0] key,
                               input logic [15:0] hdl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= op;
      req_tdata    <= {hdl, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_table_request(op, key, hdl);
      requests_sent++;
   endtask

   // Receiver: random backpressure, and the check of each accepted result
   // against the oldest outstanding prediction.
   always @(posedge clock) begin
      table_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result: status %0d prio %0d handle 0x%04h last %0b",
                   rsp_tuser, $signed(rsp_tdata[15:0]), rsp_tdata[31:16], rsp_tlast);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            status_seen[want.status]++;
            if (want.status == pst_pkg::ST_REMOVED) begin
               run_length++;
               if (run_length > longest_run) longest_run = run_length;
               if (want.last) run_length = 0;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[15:0] !== want.prio) begin
               $error("out_priority: expected %0d, actual %0d", want.prio,
                      $signed(rsp_tdata[15:0]));
               error_count++;
            end
            if (rsp_tdata[31:16] !== want.handle) begin
               $error("out_handle: expected 0x%04h, actual 0x%04h", want.handle,
                      rsp_tdata[31:16]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Remove on an empty table, extreme keys and handles, equal-key ordering,
   // and a remove whose key is absent from a non-empty table.
   task automatic test_basic_ops();
      send_request(pst_pkg::OP_REMOVE, 16'sh0000, 16'($urandom));
      send_request(pst_pkg::OP_INSERT, -16'sd32768, 16'h0000);
      send_request(pst_pkg::OP_INSERT, 16'sd32767, 16'hFFFF);
      send_request(pst_pkg::OP_INSERT, 16'sh0000, 16'h1111);
      send_request(pst_pkg::OP_INSERT, 16'sh0000, 16'h2222);
      send_request(pst_pkg::OP_REMOVE, 16'sh0000, 16'($urandom));   // two results
      send_request(pst_pkg::OP_REMOVE, 16'sd7, 16'($urandom));      // no match
      send_request(pst_pkg::OP_REMOVE, 16'sd32767, 16'($urandom));
   endtask

   // Empty the table, fill it to DEPTH with one key, get a rejected insert,
   // then pull the whole run out as the longest possible burst.
   task automatic test_full_table();
      send_request(pst_pkg::OP_REMOVE, -16'sd32768, 16'($urandom));
      while (shadow_count < DEPTH)
         send_request(pst_pkg::OP_INSERT, -16'sd1, 16'($urandom));
      send_request(pst_pkg::OP_INSERT, -16'sd1, 16'hA5A5);
      send_request(pst_pkg::OP_REMOVE, -16'sd1, 16'($urandom));
   endtask

   // Random traffic over a small key pool so removes usually hit runs; a few
   // keys from the whole range act as noise and mostly miss.
   task automatic test_random_traffic(input int n_items, input int snd_pct,
                                      input int rcv_pct);
      logic               op;
      logic signed [15:0] key;
      int                 ins_pct;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      foreach (key_pool[i]) key_pool[i] = 16'($urandom);
      key_pool[0] = -16'sd32768;
      key_pool[1] = 16'sd32767;
      for (int k = 0; k < n_items; k++) begin
         if (shadow_count == 0) ins_pct = 80;
         else if (shadow_count >= DEPTH) ins_pct = 25;
         else ins_pct = 58;
         op  = ($urandom_range(99) < ins_pct) ? pst_pkg::OP_INSERT : pst_pkg::OP_REMOVE;
         key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                         : 16'($urandom);
         send_request(op, key, 16'($urandom));
      end
   endtask

   initial begin
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 25;
      recv_idle_pct = 77;
      test_basic_ops();
      test_full_table();
      test_random_traffic(85, 25, 77);
      test_random_traffic(85, 77, 25);
      test_random_traffic(85, 0, 0);
      req_tvalid <= 1'b0;

      // drain, then give any stray result time to show up
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d requests and %0d results: %0d inserted, %0d rejected full,",
               requests_sent, results_seen, status_seen[pst_pkg::ST_INSERTED],
               status_seen[pst_pkg::ST_FULL]);
      $display("%0d removed (longest run %0d), %0d removes with no match",
               status_seen[pst_pkg::ST_REMOVED], longest_run, status_seen[pst_pkg::ST_NONE]);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/pst_pkg.sv
rtl/pst_table.sv
rtl/pst_cmp.sv
rtl/priority_sorted_table_core.sv
test/priority_sorted_table_core_test.sv
